>>> rtl/ctbs_pkg.sv
// ----------------------------------------------------------------------------
// ctbs_pkg: shared types and constants of the corrected tree broadcast scheduler
// Field widths, operation and result codes, node entry layout and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ctbs_pkg;

    localparam int MAX_NODES_DEF = 256;
    localparam int MAX_ARITY_DEF = 16;

    localparam int NODE_W     = 8;
    localparam int OP_W       = 2;
    localparam int KIND_W     = 2;
    localparam int TAG_W      = 2;
    localparam int ARITY_W    = 5;
    localparam int COUNT_W    = 9;
    localparam int OFF_W      = 10;
    localparam int STRIDE_W   = 9;
    localparam int DST_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int S_TDATA_W  = 8;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 4;
    localparam int SEL_W      = 3;

    localparam logic [OP_W-1:0] OP_TREE  = 2'd0;
    localparam logic [OP_W-1:0] OP_LEFT  = 2'd1;
    localparam logic [OP_W-1:0] OP_RIGHT = 2'd2;
    localparam logic [OP_W-1:0] OP_RING  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_SEND    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOTHING = 2'd3;

    localparam logic [TAG_W-1:0] TAG_TREE  = 2'd0;
    localparam logic [TAG_W-1:0] TAG_LEFT  = 2'd1;
    localparam logic [TAG_W-1:0] TAG_RIGHT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ARITY      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b1;

    localparam logic [ARITY_W-1:0] ARITY_RESET      = 5'd2;
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 9'd256;

    // result source selected by the controller
    localparam logic [SEL_W-1:0] SEL_CANCEL = 3'd0;
    localparam logic [SEL_W-1:0] SEL_RING   = 3'd1;
    localparam logic [SEL_W-1:0] SEL_TREE   = 3'd2;
    localparam logic [SEL_W-1:0] SEL_FIN    = 3'd3;
    localparam logic [SEL_W-1:0] SEL_NONE   = 3'd4;

    typedef struct packed {
        logic             reported;
        logic             rfin;
        logic             lfin;
        logic             tree_sent;
        logic [OFF_W-1:0] loff;
        logic [OFF_W-1:0] roff;
    } entry_t;

    typedef struct packed {
        logic             clr_we;
        logic             accept;
        logic             eval;
        logic             search_step;
        logic             tree_init;
        logic             tree_step;
        logic             mod_step;
        logic             emit;
        logic [SEL_W-1:0] sel;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic clr_last;
        logic in_range;
        logic cancel_do;
        logic ring_do;
        logic tree_do;
        logic fin_do;
        logic search_done;
        logic mod_last;
        logic tree_hit;
        logic tree_more;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/ctbs_ram.sv
// ----------------------------------------------------------------------------
// ctbs_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ctbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/ctbs_ctrl.sv
// ----------------------------------------------------------------------------
// ctbs_ctrl: scheduler controller
// Sequences the clearing sweep, entry lookup, stride search, offset modulo
// and the ordered emission of the results of one event.
// ----------------------------------------------------------------------------
`default_nettype none

module ctbs_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire ctbs_pkg::status_t status,
    output ctbs_pkg::cmd_t         cmd
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_EVAL   = 4'd2;
    localparam logic [3:0] ST_MOD    = 4'd3;
    localparam logic [3:0] ST_SEARCH = 4'd4;
    localparam logic [3:0] ST_TREE   = 4'd5;
    localparam logic [3:0] ST_CANCEL = 4'd6;
    localparam logic [3:0] ST_RING   = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;
    localparam logic [3:0] ST_NONE   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (!status.in_range) begin
                    state_next = ST_NONE;
                end else if (status.ring_do) begin
                    state_next = ST_MOD;
                end else if (status.cancel_do) begin
                    state_next = ST_CANCEL;
                end else if (status.tree_do) begin
                    state_next = ST_SEARCH;
                end else if (status.fin_do) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_NONE;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                if (status.mod_last) begin
                    state_next = status.cancel_do ? ST_CANCEL : ST_RING;
                end
            end
            ST_SEARCH: begin
                if (status.search_done) begin
                    cmd.tree_init = 1'b1;
                    state_next    = ST_TREE;
                end else begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_TREE: begin
                if (status.tree_hit) begin
                    if (status.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.sel       = ctbs_pkg::SEL_TREE;
                        cmd.tree_step = 1'b1;
                        if (status.tree_more) begin
                            state_next = ST_TREE;
                        end else if (status.fin_do) begin
                            state_next = ST_FIN;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    // no child inside the node range
                    state_next = status.fin_do ? ST_FIN : ST_NONE;
                end
            end
            ST_CANCEL: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = ctbs_pkg::SEL_CANCEL;
                    if (status.ring_do) begin
                        state_next = ST_RING;
                    end else if (status.fin_do) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RING: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = ctbs_pkg::SEL_RING;
                    state_next = status.fin_do ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = ctbs_pkg::SEL_FIN;
                    state_next = ST_IDLE;
                end
            end
            ST_NONE: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = ctbs_pkg::SEL_NONE;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("result loaded while output register is occupied");

    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_tvalid) |=> (state_reg == ST_EVAL))
        else $error("accepted transfer not followed by entry evaluation");

    a_tree_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.sel == ctbs_pkg::SEL_TREE) |-> status.tree_hit)
        else $error("tree send emitted outside node range");

    a_mod_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOD && status.mod_last)
        |=> (state_reg == ST_CANCEL || state_reg == ST_RING))
        else $error("offset reduction did not lead to ring emission");

endmodule

`default_nettype wire

>>> rtl/ctbs_dp.sv
// ----------------------------------------------------------------------------
// ctbs_dp: scheduler datapath
// Configuration registers, node entry ram, stride search, offset modulo
// unit, destination arithmetic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctbs_dp #(
    parameter int MAX_NODES = ctbs_pkg::MAX_NODES_DEF,
    parameter int MAX_ARITY = ctbs_pkg::MAX_ARITY_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic [ctbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ctbs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [ctbs_pkg::OP_W-1:0]        s_op,
    input  wire logic [ctbs_pkg::NODE_W-1:0]      s_node,
    input  wire ctbs_pkg::cmd_t                   cmd,
    output ctbs_pkg::status_t                     status,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [ctbs_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic      [ctbs_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                                  m_tlast
);

    localparam int AW    = $clog2(MAX_NODES);
    localparam int KW    = $clog2(MAX_ARITY + 1);
    localparam int PW    = ctbs_pkg::STRIDE_W + KW;
    localparam int OW    = ctbs_pkg::OFF_W;
    localparam int DW    = ctbs_pkg::DST_W;
    localparam int MCW   = $clog2(ctbs_pkg::OFF_W);
    localparam int EW    = $bits(ctbs_pkg::entry_t);

    // configuration
    logic [ctbs_pkg::ARITY_W-1:0] arity_reg;
    logic [ctbs_pkg::COUNT_W-1:0] node_count_reg;
    logic [ctbs_pkg::COUNT_W-1:0] p_eff;
    logic [KW-1:0]                k_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arity_reg      <= ctbs_pkg::ARITY_RESET;
            node_count_reg <= ctbs_pkg::NODE_COUNT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                ctbs_pkg::REG_ARITY:      arity_reg      <= cfg_data[ctbs_pkg::ARITY_W-1:0];
                ctbs_pkg::REG_NODE_COUNT: node_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (node_count_reg == '0) begin
            p_eff = ctbs_pkg::COUNT_W'(1);
        end else if (32'(node_count_reg) > 32'(MAX_NODES)) begin
            p_eff = ctbs_pkg::COUNT_W'(MAX_NODES);
        end else begin
            p_eff = node_count_reg;
        end
        if (arity_reg < ctbs_pkg::ARITY_W'(2)) begin
            k_eff = KW'(2);
        end else if (32'(arity_reg) > 32'(MAX_ARITY)) begin
            k_eff = KW'(MAX_ARITY);
        end else begin
            k_eff = KW'(arity_reg);
        end
    end

    // event and entry storage
    logic [ctbs_pkg::OP_W-1:0]   op_reg;
    logic [ctbs_pkg::NODE_W-1:0] node_reg;
    logic [AW-1:0]               clr_cnt_reg;
    ctbs_pkg::entry_t            rd_entry;
    ctbs_pkg::entry_t            wr_entry;
    logic [EW-1:0]               ram_rdata;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [EW-1:0]               ram_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_we) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_op;
            node_reg <= s_node;
        end
    end

    assign rd_entry = ctbs_pkg::entry_t'(ram_rdata);

    // plan of the event, from the looked-up entry
    logic lf_c, rf_c, in_range_c, ring_do_c, ring_left_c;
    logic cancel_do_c, tree_do_c, fin_do_c;
    logic [OW-1:0] loff_inc, roff_inc;

    always_comb begin
        in_range_c  = ctbs_pkg::COUNT_W'(node_reg) < p_eff;
        lf_c        = rd_entry.lfin | (op_reg == ctbs_pkg::OP_RIGHT);
        rf_c        = rd_entry.rfin | (op_reg == ctbs_pkg::OP_LEFT);
        cancel_do_c = in_range_c &&
                      (op_reg == ctbs_pkg::OP_LEFT || op_reg == ctbs_pkg::OP_RIGHT);
        tree_do_c   = in_range_c && op_reg == ctbs_pkg::OP_TREE && !rd_entry.tree_sent;
        ring_do_c   = in_range_c && op_reg != ctbs_pkg::OP_TREE && rd_entry.tree_sent &&
                      (!lf_c || !rf_c);
        ring_left_c = !lf_c && (rf_c || rd_entry.loff <= rd_entry.roff);
        fin_do_c    = in_range_c && op_reg != ctbs_pkg::OP_RING && lf_c && rf_c &&
                      !rd_entry.reported;
        loff_inc    = (rd_entry.loff == '1) ? rd_entry.loff : rd_entry.loff + 1'b1;
        roff_inc    = (rd_entry.roff == '1) ? rd_entry.roff : rd_entry.roff + 1'b1;

        wr_entry           = rd_entry;
        wr_entry.lfin      = lf_c;
        wr_entry.rfin      = rf_c;
        wr_entry.tree_sent = rd_entry.tree_sent | (op_reg == ctbs_pkg::OP_TREE);
        wr_entry.reported  = rd_entry.reported | fin_do_c;
        if (ring_do_c && ring_left_c) begin
            wr_entry.loff = loff_inc;
        end
        if (ring_do_c && !ring_left_c) begin
            wr_entry.roff = roff_inc;
        end
    end

    // out-of-range nodes may alias a live entry, so no write for them
    assign ram_we    = cmd.clr_we || (cmd.eval && in_range_c);
    assign ram_waddr = cmd.clr_we ? clr_cnt_reg : AW'(node_reg);
    assign ram_wdata = cmd.clr_we ? '0 : EW'(wr_entry);

    ctbs_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_NODES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (AW'(s_node)),
        .rdata (ram_rdata)
    );

    // registered plan
    logic in_range_reg, cancel_do_reg, ring_do_reg, ring_left_reg, tree_do_reg, fin_do_reg;

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            in_range_reg  <= in_range_c;
            cancel_do_reg <= cancel_do_c;
            ring_do_reg   <= ring_do_c;
            ring_left_reg <= ring_left_c;
            tree_do_reg   <= tree_do_c;
            fin_do_reg    <= fin_do_c;
        end
    end

    // stride search and child walk
    logic [ctbs_pkg::STRIDE_W-1:0] stride_reg;
    logic [DW-1:0]                 dst_reg;
    logic [KW-1:0]                 idx_reg;
    logic [PW-1:0]                 prod;
    logic [PW-1:0]                 n_plus1;
    logic [DW-1:0]                 dst_ahead;

    assign prod      = PW'(stride_reg) * PW'(k_eff);
    assign n_plus1   = PW'(node_reg) + PW'(1);
    assign dst_ahead = dst_reg + DW'(stride_reg);

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            stride_reg <= ctbs_pkg::STRIDE_W'(1);
        end else if (cmd.search_step) begin
            stride_reg <= prod[ctbs_pkg::STRIDE_W-1:0];
        end
        if (cmd.tree_init) begin
            dst_reg <= DW'(node_reg) + DW'(stride_reg);
            idx_reg <= KW'(1);
        end else if (cmd.tree_step) begin
            dst_reg <= dst_ahead;
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // offset mod node count, one remainder bit per cycle
    logic [OW-1:0]  off_reg;
    logic [OW-1:0]  rem_reg;
    logic [MCW-1:0] mod_cnt_reg;
    logic [OW-1:0]  rem_shift;
    logic [OW-1:0]  p_ext;

    assign p_ext     = OW'(p_eff);
    assign rem_shift = {rem_reg[OW-2:0], off_reg[mod_cnt_reg]};

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            off_reg     <= ring_left_c ? loff_inc : roff_inc;
            rem_reg     <= '0;
            mod_cnt_reg <= MCW'(OW - 1);
        end else if (cmd.mod_step) begin
            rem_reg     <= (rem_shift >= p_ext) ? rem_shift - p_ext : rem_shift;
            mod_cnt_reg <= mod_cnt_reg - 1'b1;
        end
    end

    logic [DW-1:0] ring_raw;
    logic [DW-1:0] ring_dst;

    always_comb begin
        if (ring_left_reg) begin
            ring_raw = DW'(node_reg) + DW'(p_eff) - DW'(rem_reg);
        end else begin
            ring_raw = DW'(node_reg) + DW'(rem_reg);
        end
        ring_dst = (ring_raw >= DW'(p_eff)) ? ring_raw - DW'(p_eff) : ring_raw;
    end

    // status back to the controller
    always_comb begin
        status.out_free    = !m_tvalid || m_tready;
        status.clr_last    = (clr_cnt_reg == AW'(MAX_NODES - 1));
        status.in_range    = cmd.eval ? in_range_c  : in_range_reg;
        status.cancel_do   = cmd.eval ? cancel_do_c : cancel_do_reg;
        status.ring_do     = cmd.eval ? ring_do_c   : ring_do_reg;
        status.tree_do     = cmd.eval ? tree_do_c   : tree_do_reg;
        status.fin_do      = cmd.eval ? fin_do_c    : fin_do_reg;
        status.search_done = prod > n_plus1;
        status.mod_last    = (mod_cnt_reg == '0);
        status.tree_hit    = dst_reg < DW'(p_eff);
        status.tree_more   = (idx_reg < k_eff) && (dst_ahead < DW'(p_eff));
    end

    // output register
    logic                          out_valid_reg;
    logic [ctbs_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [ctbs_pkg::TAG_W-1:0]    tag_reg, tag_next;
    logic [ctbs_pkg::NODE_W-1:0]   to_reg, to_next;
    logic                          last_reg, last_next;

    always_comb begin
        kind_next = ctbs_pkg::KIND_NOTHING;
        tag_next  = ctbs_pkg::TAG_TREE;
        to_next   = '0;
        last_next = 1'b1;
        case (cmd.sel)
            ctbs_pkg::SEL_CANCEL: begin
                kind_next = ctbs_pkg::KIND_CANCEL;
                tag_next  = (op_reg == ctbs_pkg::OP_LEFT) ? ctbs_pkg::TAG_RIGHT
                                                          : ctbs_pkg::TAG_LEFT;
                last_next = !(ring_do_reg || fin_do_reg);
            end
            ctbs_pkg::SEL_RING: begin
                kind_next = ctbs_pkg::KIND_SEND;
                tag_next  = ring_left_reg ? ctbs_pkg::TAG_LEFT : ctbs_pkg::TAG_RIGHT;
                to_next   = ring_dst[ctbs_pkg::NODE_W-1:0];
                last_next = !fin_do_reg;
            end
            ctbs_pkg::SEL_TREE: begin
                kind_next = ctbs_pkg::KIND_SEND;
                to_next   = dst_reg[ctbs_pkg::NODE_W-1:0];
                last_next = !(status.tree_more || fin_do_reg);
            end
            ctbs_pkg::SEL_FIN: begin
                kind_next = ctbs_pkg::KIND_FINISH;
            end
            default: begin
                kind_next = ctbs_pkg::KIND_NOTHING;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    logic [ctbs_pkg::NODE_W-1:0] from_reg;

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            kind_reg <= kind_next;
            tag_reg  <= tag_next;
            from_reg <= node_reg;
            to_reg   <= to_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {to_reg, from_reg};
    assign m_tuser  = {tag_reg, kind_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

>>> rtl/corrected_tree_broadcast_scheduler.sv
// ----------------------------------------------------------------------------
// corrected_tree_broadcast_scheduler: per-node tree and ring broadcast control
// Tracks tree and ring-correction progress per node and answers each node
// event with the sends, cancels and finish reports that it causes.
// ----------------------------------------------------------------------------
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tuser: op[1:0]; s_tdata: node[7:0]
// m_       out  m_tvalid/m_tready    m_tuser: kind[1:0] tag[3:2];
//                                    m_tdata: from_node[7:0] to_node[15:8]; m_tlast
// cfg_     in   cfg_valid/cfg_ready  cfg_index: 0 arity, 1 node_count; cfg_data[8:0]
//
// an event looks up and updates its node entry, then its results leave one per cycle
// while the output register is free; a ring hop adds the bit-serial offset reduction,
// a tree message adds the stride search for the largest k^L <= node+1
// and emits up to k sends; one event is in flight at a time
// after reset a clearing sweep over all MAX_NODES entries zeroes the node entry ram,
// with s_tready low meanwhile; configuration writes are taken at any time
// a stalled output register holds the emission sequence; the next event is
// taken as soon as the previous one has loaded its last result
// ----------------------------------------------------------------------------
`default_nettype none

module corrected_tree_broadcast_scheduler #(
    parameter int MAX_NODES = ctbs_pkg::MAX_NODES_DEF,
    parameter int MAX_ARITY = ctbs_pkg::MAX_ARITY_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ctbs_pkg::S_TDATA_W-1:0]   s_tdata,   // node
    input  wire logic [ctbs_pkg::S_TUSER_W-1:0]   s_tuser,   // op
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [ctbs_pkg::M_TDATA_W-1:0]   m_tdata,   // from_node, to_node
    output logic      [ctbs_pkg::M_TUSER_W-1:0]   m_tuser,   // kind, tag
    output logic                                  m_tlast,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ctbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ctbs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    ctbs_pkg::cmd_t    cmd;
    ctbs_pkg::status_t status;

    assign cfg_ready = 1'b1;

    ctbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ctbs_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_ARITY (MAX_ARITY)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_op      (s_tuser[ctbs_pkg::OP_W-1:0]),
        .s_node    (s_tdata[ctbs_pkg::NODE_W-1:0]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

>>> tb/ctbs_checker.sv
// ----------------------------------------------------------------------------
// ctbs_checker: scoreboard for the corrected tree broadcast scheduler
// Follows the event, result and register write transfers, keeps its own copy
// of the per-node tree and ring progress, predicts the sends, cancels and
// finish reports of every accepted event and compares results in order.
// ----------------------------------------------------------------------------
module ctbs_checker
    import ctbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // node
    input  logic [S_TUSER_W-1:0]  s_tuser,    // op
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,    // from_node, to_node
    input  logic [M_TUSER_W-1:0]  m_tuser,    // kind, tag
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFFSET_TOP = 1023;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [7:0]        from_node;
        logic [7:0]        to_node;
        logic              last;
    } action_t;

    action_t expected_actions[$];

    logic [ARITY_W-1:0] arity_reg;
    logic [COUNT_W-1:0] count_reg;

    bit         tree_sent    [0:MAX_NODES_DEF-1];
    bit         left_closed  [0:MAX_NODES_DEF-1];
    bit         right_closed [0:MAX_NODES_DEF-1];
    bit         finish_sent  [0:MAX_NODES_DEF-1];
    logic [9:0] left_off     [0:MAX_NODES_DEF-1];
    logic [9:0] right_off    [0:MAX_NODES_DEF-1];

    function automatic string show(input action_t a);
        return $sformatf("kind %0d tag %0d from %0d to %0d last %0d",
                         a.kind, a.tag, a.from_node, a.to_node, a.last);
    endfunction

    task automatic report(input string what, input action_t got, input action_t want);
        fail_count++;
        if (fail_count <= 100) begin
            $display("%0t ctbs_checker: %s: got %s / want %s", $time, what, show(got),
                     show(want));
        end
    endtask

    function automatic void push_action(input logic [KIND_W-1:0] kind,
                                        input logic [TAG_W-1:0] tag, input int src,
                                        input int dst);
        action_t a;
        a.kind      = kind;
        a.tag       = tag;
        a.from_node = src[7:0];
        a.to_node   = dst[7:0];
        a.last      = 1'b0;
        expected_actions.push_back(a);
    endfunction

    // one further correction hop, the lagging direction first while both are open
    function automatic void ring_hop(input int n, input int p);
        bit go_left;
        int off;
        if (!tree_sent[n]) return;
        if (!left_closed[n] && !right_closed[n]) go_left = (left_off[n] <= right_off[n]);
        else if (!left_closed[n]) go_left = 1'b1;
        else if (!right_closed[n]) go_left = 1'b0;
        else return;
        if (go_left) begin
            if (left_off[n] < OFFSET_TOP) left_off[n]++;
            off = int'(left_off[n]) % p;
            push_action(KIND_SEND, TAG_LEFT, n, (n + p - off) % p);
        end else begin
            if (right_off[n] < OFFSET_TOP) right_off[n]++;
            off = int'(right_off[n]) % p;
            push_action(KIND_SEND, TAG_RIGHT, n, (n + off) % p);
        end
    endfunction

    task automatic predict_actions(input logic [OP_W-1:0] op, input logic [7:0] node);
        int p, k, n, first, stride, dst;
        p = (count_reg < 1) ? 1 : (count_reg > MAX_NODES_DEF) ? MAX_NODES_DEF : count_reg;
        k = (arity_reg < 2) ? 2 : (arity_reg > MAX_ARITY_DEF) ? MAX_ARITY_DEF : arity_reg;
        n = int'(node);
        first = expected_actions.size();
        if (n < p) begin
            case (op)
                OP_TREE: begin
                    if (!tree_sent[n]) begin
                        // stride is the largest power of k not above node+1
                        stride = 1;
                        while (stride * k <= n + 1) stride *= k;
                        for (int i = 1; i <= k; i++) begin
                            dst = n + i * stride;
                            if (dst < p) push_action(KIND_SEND, TAG_TREE, n, dst);
                        end
                        tree_sent[n] = 1'b1;
                    end
                end
                OP_LEFT: begin
                    right_closed[n] = 1'b1;
                    push_action(KIND_CANCEL, TAG_RIGHT, n, 0);
                    ring_hop(n, p);
                end
                OP_RIGHT: begin
                    left_closed[n] = 1'b1;
                    push_action(KIND_CANCEL, TAG_LEFT, n, 0);
                    ring_hop(n, p);
                end
                default: begin
                    ring_hop(n, p);
                end
            endcase
            if (op != OP_RING && left_closed[n] && right_closed[n] && !finish_sent[n]) begin
                push_action(KIND_FINISH, TAG_TREE, n, 0);
                finish_sent[n] = 1'b1;
            end
        end
        if (expected_actions.size() == first) push_action(KIND_NOTHING, TAG_TREE, n, 0);
        expected_actions[expected_actions.size() - 1].last = 1'b1;
    endtask

    always @(posedge aclk) begin
        action_t got;
        action_t want;
        if (!aresetn) begin
            arity_reg = ARITY_RESET;
            count_reg = NODE_COUNT_RESET;
            for (int i = 0; i < MAX_NODES_DEF; i++) begin
                tree_sent[i]    = 1'b0;
                left_closed[i]  = 1'b0;
                right_closed[i] = 1'b0;
                finish_sent[i]  = 1'b0;
                left_off[i]     = '0;
                right_off[i]    = '0;
            end
            expected_actions.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_ARITY) arity_reg = cfg_data[ARITY_W-1:0];
                else if (cfg_index == REG_NODE_COUNT) count_reg = cfg_data[COUNT_W-1:0];
            end
            if (s_tvalid && s_tready) predict_actions(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                got.kind      = m_tuser[1:0];
                got.tag       = m_tuser[3:2];
                got.from_node = m_tdata[7:0];
                got.to_node   = m_tdata[15:8];
                got.last      = m_tlast;
                if (expected_actions.size() == 0) begin
                    report("result with nothing expected", got, '0);
                end else begin
                    want = expected_actions.pop_front();
                    if (got.kind != want.kind || got.tag != want.tag ||
                        got.from_node != want.from_node || got.to_node != want.to_node ||
                        got.last != want.last) begin
                        report("result mismatch", got, want);
                    end
                end
            end
        end
        pending = expected_actions.size();
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the corrected tree broadcast scheduler
// Drives node events and register writes with random gaps and output stalls,
// walks through several fan-out and node count settings, runs directed ring
// hops on two fresh nodes, and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module tb;
    import ctbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;    // node
    logic [S_TUSER_W-1:0]  s_tuser   = '0;    // op
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;           // from_node, to_node
    logic [M_TUSER_W-1:0]  m_tuser;           // kind, tag
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    int hold_left    = 0;
    bit no_gaps      = 1'b0;
    bit hold_req     = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    corrected_tree_broadcast_scheduler u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ctbs_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // result side: random back-pressure, or a long hold-off when requested
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_gaps || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic send_event(input logic [OP_W-1:0] op, input logic [7:0] node);
        @(negedge aclk);
        while (!no_gaps && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= node;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // drop valid right after the last transfer, then wait for the results to drain
    task automatic settle;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic random_events(input int count, input int p_eff);
        int r;
        logic [OP_W-1:0] op;
        logic [7:0] node;
        for (int i = 0; i < count; i++) begin
            r  = $urandom_range(0, 99);
            op = (r < 25) ? OP_TREE : (r < 37) ? OP_LEFT : (r < 49) ? OP_RIGHT : OP_RING;
            if ($urandom_range(0, 99) < 85) node = 8'($urandom_range(0, p_eff - 1));
            else node = 8'($urandom_range(0, 255));
            // nodes 200 and 201 are kept fresh for the directed ring runs
            if (node == 8'd200 || node == 8'd201) node = node ^ 8'h10;
            send_event(op, node);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings, binary tree over 256 nodes
        send_event(OP_RING, 8'd5);      // ring hop before any tree message
        send_event(OP_TREE, 8'd0);
        send_event(OP_TREE, 8'd0);      // repeated tree message
        send_event(OP_TREE, 8'd255);    // children fall beyond the last node
        send_event(OP_RING, 8'd0);
        send_event(OP_RING, 8'd0);
        send_event(OP_LEFT, 8'd0);
        send_event(OP_RIGHT, 8'd0);     // both directions done, finish
        send_event(OP_RIGHT, 8'd0);     // finish only once
        send_event(OP_RING, 8'd0);      // nothing left to send
        send_event(OP_LEFT, 8'd255);
        send_event(OP_RIGHT, 8'd255);   // finish without tree phase
        send_event(OP_TREE, 8'd7);
        settle();

        // widest fan-out, node count above range
        write_reg(REG_ARITY, 9'h1F0);
        write_reg(REG_NODE_COUNT, 9'h1FF);
        send_event(OP_TREE, 8'd20);
        hold_req = 1'b1;
        send_event(OP_TREE, 8'd1);      // full sixteen-way fan-out
        send_event(OP_RING, 8'd1);
        send_event(OP_LEFT, 8'd1);
        send_event(OP_RIGHT, 8'd1);
        random_events(10, 256);
        settle();

        // both registers below range: binary tree, single node
        write_reg(REG_ARITY, 9'h000);
        write_reg(REG_NODE_COUNT, 9'h000);
        send_event(OP_TREE, 8'd0);
        send_event(OP_RING, 8'd0);
        send_event(OP_LEFT, 8'd1);      // node outside the ring
        send_event(OP_TREE, 8'd255);
        random_events(12, 1);
        settle();

        // small ring with wrap-around, no gaps on either side
        write_reg(REG_ARITY, 9'h003);
        write_reg(REG_NODE_COUNT, 9'h005);
        no_gaps = 1'b1;
        random_events(25, 5);
        settle();
        no_gaps = 1'b0;

        // arity above range; one-sided ring hops on fresh nodes
        write_reg(REG_ARITY, 9'h011);
        write_reg(REG_NODE_COUNT, 9'h100);
        send_event(OP_TREE, 8'd200);
        send_event(OP_LEFT, 8'd200);
        repeat (3) send_event(OP_RING, 8'd200);
        send_event(OP_RIGHT, 8'd200);
        send_event(OP_TREE, 8'd201);
        send_event(OP_RIGHT, 8'd201);
        repeat (3) send_event(OP_RING, 8'd201);
        send_event(OP_LEFT, 8'd201);
        random_events(15, 256);
        settle();

        // arity one acts as two, hundred nodes
        write_reg(REG_ARITY, 9'h001);
        write_reg(REG_NODE_COUNT, 9'h064);
        random_events(10, 100);
        settle();

        if (fail_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
